FILE: hdl/lbba_pkg.sv
// Shared types and codes for the label bounding box accumulator.
// Depends on nothing; imported by the top level.
`default_nettype none
package lbba_pkg;

   // Operation codes of the input word.
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_PIXEL       = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_CLASS_MASK  = 1'b0;
   localparam logic CSR_FRAME_WIDTH = 1'b1;

   localparam int CSR_DATA_BITS = 13;

   // Control states, one-hot.
   typedef enum logic [3:0] {
      ST_RUN   = 4'b0001,
      ST_DRAIN = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/label_bounding_box_accumulator.sv
// Label bounding box accumulator top level. Depends on lbba_pkg and lbba_ram.
//
// Pixels and label table writes are taken one word per clock while input is
// not stalled. Each pixel is matched against all table entries in parallel,
// and its rectangle is updated by a read-modify-write of the rectangle RAM,
// with forwarding of the previous write so that back-to-back pixels of the
// same region chain. After the word marked last, input is stalled while the
// block drains the pipeline and then scans all NUM_CLASSES*REGION_SLOTS
// rectangles, stepping past closed ones and reading out each open one once
// the result register is free; result-side stalls lengthen the scan. The
// scan, not the pixel path, sets the gap between frames.
`default_nettype none
module label_bounding_box_accumulator #(
   parameter int LABEL_ENTRIES = 64,
   parameter int NUM_CLASSES   = 8,
   parameter int REGION_SLOTS  = 8,
   parameter int COORD_BITS    = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write,
   input  wire logic                         csr_index,
   input  wire logic [lbba_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_op,
   input  wire logic [5:0]                   req_entry_index,
   input  wire logic                         req_entry_valid,
   input  wire logic [23:0]                  req_entry_handle,
   input  wire logic [2:0]                   req_entry_class,
   input  wire logic [2:0]                   req_entry_slot,
   input  wire logic [23:0]                  req_pixel_id,
   input  wire logic                         req_last_pixel,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_box_valid,
   output logic [2:0]                        rsp_box_class,
   output logic [2:0]                        rsp_box_slot,
   output logic [COORD_BITS-1:0]             rsp_min_row,
   output logic [COORD_BITS-1:0]             rsp_max_row,
   output logic [COORD_BITS-1:0]             rsp_min_col,
   output logic [COORD_BITS-1:0]             rsp_max_col,
   output logic                              rsp_last
);
   import lbba_pkg::*;

   localparam int RECTS   = NUM_CLASSES * REGION_SLOTS;
   localparam int RA_BITS = (RECTS > 1) ? $clog2(RECTS) : 1;
   localparam int LI_BITS = (LABEL_ENTRIES > 1) ? $clog2(LABEL_ENTRIES) : 1;
   localparam int SB      = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int CB      = $clog2(NUM_CLASSES + 1);
   localparam int RW      = 4 * COORD_BITS;
   localparam int WB      = 17;

   localparam logic [WB-1:0] WIDTH_LIMIT = WB'(1) << COORD_BITS;

   // Configuration registers.
   logic [7:0]  class_mask_ff;
   logic [12:0] frame_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_mask_ff  <= 8'd255;
         frame_width_ff <= 13'd640;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CLASS_MASK:  class_mask_ff  <= csr_data[7:0];
            CSR_FRAME_WIDTH: frame_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;

   logic accept;
   assign req_stall = (state_ff != ST_RUN);
   assign accept    = req_valid && !req_stall;

   // Label table: valid bits reset, payload written by table words.
   logic              lt_valid_ff  [LABEL_ENTRIES];
   logic [23:0]       lt_handle_ff [LABEL_ENTRIES];
   logic [2:0]        lt_class_ff  [LABEL_ENTRIES];
   logic [2:0]        lt_slot_ff   [LABEL_ENTRIES];
   logic [LI_BITS+5:0] wr_index_wide;
   logic [LI_BITS-1:0] wr_index;
   logic               lt_write;

   assign wr_index_wide = (LI_BITS + 6)'(req_entry_index);
   assign wr_index      = wr_index_wide[LI_BITS-1:0];
   assign lt_write      = accept && (req_op == OP_TABLE_WRITE)
                          && (int'(req_entry_index) < LABEL_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LABEL_ENTRIES; i++) begin
            lt_valid_ff[i] <= 1'b0;
         end
      end else if (lt_write) begin
         lt_valid_ff[wr_index] <= req_entry_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (lt_write) begin
         lt_handle_ff[wr_index] <= req_entry_handle;
         lt_class_ff[wr_index]  <= req_entry_class;
         lt_slot_ff[wr_index]   <= req_entry_slot;
      end
   end

   // Parallel match; the lowest active index wins.
   logic       match_hit;
   logic [2:0] match_class;
   logic [2:0] match_slot;
   logic       match_en;
   logic [RA_BITS-1:0] match_addr;

   always_comb begin
      match_hit   = 1'b0;
      match_class = 3'd0;
      match_slot  = 3'd0;
      for (int i = LABEL_ENTRIES - 1; i >= 0; i--) begin
         if (lt_valid_ff[i] && lt_handle_ff[i] == req_pixel_id) begin
            match_hit   = 1'b1;
            match_class = lt_class_ff[i];
            match_slot  = lt_slot_ff[i];
         end
      end
      match_en = match_hit && (int'(match_class) < NUM_CLASSES)
                 && (int'(match_slot) < REGION_SLOTS) && class_mask_ff[match_class];
      match_addr = RA_BITS'(int'(match_class) * REGION_SLOTS + int'(match_slot));
   end

   // Raster counters.
   logic [COORD_BITS-1:0] row_ff, row_in, col_ff, col_in;
   logic [WB-1:0]         width_eff, col_next;
   logic                  pixel_accept;

   assign pixel_accept = accept && (req_op == OP_PIXEL);

   always_comb begin
      width_eff = WB'(frame_width_ff);
      if (width_eff == '0) begin
         width_eff = WB'(1);
      end
      if (width_eff > WIDTH_LIMIT) begin
         width_eff = WIDTH_LIMIT;
      end
      col_next = WB'(col_ff) + WB'(1);
      row_in = row_ff;
      col_in = col_ff;
      if (pixel_accept) begin
         if (req_last_pixel) begin
            row_in = '0;
            col_in = '0;
         end else if (col_next >= width_eff) begin
            col_in = '0;
            row_in = row_ff + COORD_BITS'(1);
         end else begin
            col_in = col_next[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Update stage: the RAM read issued at accept returns here.
   logic                  s1_valid_ff;
   logic [RA_BITS-1:0]    s1_addr_ff;
   logic [COORD_BITS-1:0] s1_row_ff, s1_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pixel_accept && match_en;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= match_addr;
      s1_row_ff  <= row_ff;
      s1_col_ff  <= col_ff;
   end

   logic              fwd_valid_ff;
   logic [RA_BITS-1:0] fwd_addr_ff;
   logic [RW-1:0]     fwd_data_ff;
   logic [RW-1:0]     ram_rdata, cur_rect, new_rect;
   logic              rect_open_ff [RECTS];
   logic [COORD_BITS-1:0] c_rmin, c_rmax, c_cmin, c_cmax;

   // Widen the rectangle, or open it at the pixel.
   always_comb begin
      cur_rect = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : ram_rdata;
      {c_rmin, c_rmax, c_cmin, c_cmax} = cur_rect;
      if (!rect_open_ff[s1_addr_ff]) begin
         new_rect = {s1_row_ff, s1_row_ff, s1_col_ff, s1_col_ff};
      end else begin
         new_rect = {(s1_row_ff < c_rmin) ? s1_row_ff : c_rmin,
                     (s1_row_ff > c_rmax) ? s1_row_ff : c_rmax,
                     (s1_col_ff < c_cmin) ? s1_col_ff : c_cmin,
                     (s1_col_ff > c_cmax) ? s1_col_ff : c_cmax};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= new_rect;
   end

   // Scan of the rectangles after the last pixel.
   logic [CB-1:0]      scan_cls_ff, scan_cls_in;
   logic [SB-1:0]      scan_slot_ff, scan_slot_in;
   logic               emitted_ff, emitted_in;
   logic [RA_BITS-1:0] scan_addr, ram_raddr;
   logic               scan_done, out_free, any_above, advance;

   assign scan_addr = RA_BITS'(int'(scan_cls_ff) * REGION_SLOTS + int'(scan_slot_ff));
   assign scan_done = (int'(scan_cls_ff) == NUM_CLASSES);
   assign out_free  = !rsp_valid || !rsp_stall;
   assign ram_raddr = (state_ff == ST_RUN) ? match_addr : scan_addr;

   always_comb begin
      any_above = 1'b0;
      for (int j = 0; j < RECTS; j++) begin
         if (j > int'(scan_addr) && rect_open_ff[j]) begin
            any_above = 1'b1;
         end
      end
   end

   lbba_ram #(
      .WIDTH (RW),
      .DEPTH (RECTS)
   ) u_rect_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (new_rect),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Result word register.
   logic load_rect, load_empty;

   always_comb begin
      state_in     = state_ff;
      scan_cls_in  = scan_cls_ff;
      scan_slot_in = scan_slot_ff;
      emitted_in   = emitted_ff;
      load_rect    = 1'b0;
      load_empty   = 1'b0;
      advance      = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (pixel_accept && req_last_pixel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_done) begin
               if (emitted_ff) begin
                  state_in = ST_RUN;
               end else if (out_free) begin
                  load_empty = 1'b1;
                  state_in   = ST_RUN;
               end
            end else if (!rect_open_ff[scan_addr]) begin
               advance = 1'b1;
            end else if (out_free) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            load_rect  = 1'b1;
            advance    = 1'b1;
            emitted_in = 1'b1;
            state_in   = ST_SCAN;
         end
         default: state_in = ST_RUN;
      endcase
      if (advance) begin
         if (int'(scan_slot_ff) == REGION_SLOTS - 1) begin
            scan_slot_in = '0;
            scan_cls_in  = scan_cls_ff + CB'(1);
         end else begin
            scan_slot_in = scan_slot_ff + SB'(1);
         end
      end
      if (state_ff == ST_SCAN && scan_done && state_in == ST_RUN) begin
         scan_cls_in  = '0;
         scan_slot_in = '0;
         emitted_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         scan_cls_ff  <= '0;
         scan_slot_ff <= '0;
         emitted_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cls_ff  <= scan_cls_in;
         scan_slot_ff <= scan_slot_in;
         emitted_ff   <= emitted_in;
      end
   end

   // Open flags: set by the update stage, cleared as the scan emits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RECTS; i++) begin
            rect_open_ff[i] <= 1'b0;
         end
      end else begin
         if (s1_valid_ff) begin
            rect_open_ff[s1_addr_ff] <= 1'b1;
         end
         if (load_rect) begin
            rect_open_ff[scan_addr] <= 1'b0;
         end
      end
   end

   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rect || load_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rect) begin
         rsp_box_valid <= 1'b1;
         rsp_box_class <= 3'(scan_cls_ff);
         rsp_box_slot  <= 3'(scan_slot_ff);
         {rsp_min_row, rsp_max_row, rsp_min_col, rsp_max_col} <= ram_rdata;
         rsp_last      <= !any_above;
      end else if (load_empty) begin
         rsp_box_valid <= 1'b0;
         rsp_box_class <= 3'd0;
         rsp_box_slot  <= 3'd0;
         rsp_min_row   <= '0;
         rsp_max_row   <= '0;
         rsp_min_col   <= '0;
         rsp_max_col   <= '0;
         rsp_last      <= 1'b1;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/lbba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lbba_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read; a read of the written entry returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: tb/label_bounding_box_accumulator_test.sv
// Self-checking test of the label bounding box accumulator: drives table writes and
// pixel frames, predicts every emitted rectangle and compares it field by field.
// Depends on lbba_pkg and the label_bounding_box_accumulator RTL.
`default_nettype none
module label_bounding_box_accumulator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lbba_pkg::*;

   localparam int TABLE_SIZE = 64;
   localparam int RECTS      = 64;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic        box_valid;
      logic [2:0]  box_class;
      logic [2:0]  box_slot;
      logic [11:0] min_row;
      logic [11:0] max_row;
      logic [11:0] min_col;
      logic [11:0] max_col;
      logic        last;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic csr_index = CSR_CLASS_MASK;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = OP_PIXEL;
   logic [5:0] req_entry_index = '0;
   logic req_entry_valid = 1'b0;
   logic [23:0] req_entry_handle = '0;
   logic [2:0] req_entry_class = '0;
   logic [2:0] req_entry_slot = '0;
   logic [23:0] req_pixel_id = '0;
   logic req_last_pixel = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_box_valid;
   logic [2:0] rsp_box_class, rsp_box_slot;
   logic [11:0] rsp_min_row, rsp_max_row, rsp_min_col, rsp_max_col;
   logic rsp_last;

   label_bounding_box_accumulator dut (.*);

   // Predictor state: mirror of the label table, rectangles, counters, registers.
   logic [7:0]  mask_copy = 8'hFF;
   logic [12:0] width_copy = 13'd640;
   logic        entry_on[TABLE_SIZE];
   logic [23:0] entry_id[TABLE_SIZE];
   logic [2:0]  entry_cls[TABLE_SIZE];
   logic [2:0]  entry_slt[TABLE_SIZE];
   logic        rect_on[RECTS];
   logic [11:0] rect_r0[RECTS], rect_r1[RECTS], rect_c0[RECTS], rect_c1[RECTS];
   logic [11:0] row_now = '0, col_now = '0;

   box_type expected_boxes[$];
   int mismatches = 0;
   int cycles = 0;
   bit noisy = 1'b1;          // random idling enabled
   bit hold_off = 1'b0;       // long receiver stall request
   logic [23:0] ids[8];       // handles used by well-formed frames

   initial forever #2 clock = ~clock;

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) entry_on[i] = 1'b0;
      for (int i = 0; i < RECTS; i++) rect_on[i] = 1'b0;
   end

   // Work out the boxes one accepted word produces.
   task automatic predict_boxes(input logic op, input logic [5:0] idx, input logic ev,
                                input logic [23:0] h, input logic [2:0] c,
                                input logic [2:0] s, input logic [23:0] pix,
                                input logic lst);
      int hit;
      int r;
      int w;
      int n;
      box_type b;
      hit = -1;
      n = 0;
      if (op == OP_TABLE_WRITE) begin
         entry_on[idx] = ev;
         entry_id[idx] = h;
         entry_cls[idx] = c;
         entry_slt[idx] = s;
         return;
      end
      for (int i = 0; i < TABLE_SIZE; i++)
         if (hit < 0 && entry_on[i] && entry_id[i] == pix) hit = i;
      if (hit >= 0 && mask_copy[entry_cls[hit]]) begin
         r = entry_cls[hit] * 8 + entry_slt[hit];
         if (!rect_on[r]) begin
            rect_on[r] = 1'b1;
            rect_r0[r] = row_now; rect_r1[r] = row_now;
            rect_c0[r] = col_now; rect_c1[r] = col_now;
         end else begin
            if (row_now < rect_r0[r]) rect_r0[r] = row_now;
            if (row_now > rect_r1[r]) rect_r1[r] = row_now;
            if (col_now < rect_c0[r]) rect_c0[r] = col_now;
            if (col_now > rect_c1[r]) rect_c1[r] = col_now;
         end
      end
      w = (width_copy == 0) ? 1 : (width_copy > 4096 ? 4096 : width_copy);
      if (col_now + 1 >= w) begin
         col_now = '0;
         row_now = row_now + 1'b1;
      end else begin
         col_now = col_now + 1'b1;
      end
      if (!lst) return;
      for (int i = 0; i < RECTS; i++) begin
         if (rect_on[i]) begin
            b = '{1'b1, 3'(i / 8), 3'(i % 8), rect_r0[i], rect_r1[i],
                  rect_c0[i], rect_c1[i], 1'b0};
            expected_boxes.push_back(b);
            rect_on[i] = 1'b0;
            n++;
         end
      end
      if (n == 0) expected_boxes.push_back('{1'b0, 3'd0, 3'd0, 12'd0, 12'd0, 12'd0,
                                             12'd0, 1'b1});
      else expected_boxes[$].last = 1'b1;
      row_now = '0;
      col_now = '0;
   endtask

   // Offer one word, wait for acceptance, and predict its results. Valid stays
   // high afterwards so the next word can follow at once; idling drops it.
   task automatic send_word(input logic op, input logic [5:0] idx, input logic ev,
                            input logic [23:0] h, input logic [2:0] c,
                            input logic [2:0] s, input logic [23:0] pix,
                            input logic lst);
      if (noisy && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_entry_index <= idx;
      req_entry_valid <= ev;
      req_entry_handle <= h;
      req_entry_class <= c;
      req_entry_slot <= s;
      req_pixel_id <= pix;
      req_last_pixel <= lst;
      do @(posedge clock); while (req_stall);
      predict_boxes(op, idx, ev, h, c, s, pix, lst);
      @(negedge clock);
   endtask

   task automatic write_entry(input int idx, input logic ev, input logic [23:0] h,
                              input int c, input int s);
      send_word(OP_TABLE_WRITE, 6'(idx), ev, h, 3'(c), 3'(s), 24'($urandom),
                1'($urandom));
   endtask

   task automatic send_pixel(input logic [23:0] pix, input logic lst);
      send_word(OP_PIXEL, 6'($urandom), 1'($urandom), 24'($urandom), 3'($urandom),
                3'($urandom), pix, lst);
   endtask

   // Stop offering, then wait until all boxes are in, plus the scan's worst case.
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (expected_boxes.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [12:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_CLASS_MASK) mask_copy = value[7:0];
      else width_copy = value;
   endtask

   // Directed: edge values of handles, coordinates and table behavior.
   task automatic test_directed;
      send_pixel(24'h0, 1'b1);                          // empty frame
      write_entry(0, 1'b1, 24'hFFFFFF, 7, 7);
      write_entry(63, 1'b1, 24'h000000, 0, 0);
      write_entry(5, 1'b1, 24'hFFFFFF, 3, 2);           // duplicate, lower index wins
      write_entry(10, 1'b1, 24'hA5A5A5, 4, 1);
      write_entry(10, 1'b0, 24'hA5A5A5, 4, 1);          // removed again
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hA5A5A5, 1'b0);                     // no match now
      send_pixel(24'h123456, 1'b0);
      send_pixel(24'hFFFFFF, 1'b1);
      write_register(CSR_FRAME_WIDTH, 13'd0);           // width zero acts as one
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b1);
      write_register(CSR_FRAME_WIDTH, 13'h1FFF);        // clamps to the coordinate range
      write_register(CSR_CLASS_MASK, 13'h000);          // everything disabled
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b1);
      write_register(CSR_CLASS_MASK, 13'h081);
   endtask

   // Random frames of mostly known handles, with table rewrites as noise.
   task automatic test_random_frames(input int words);
      for (int i = 0; i < 8; i++) begin
         ids[i] = 24'($urandom);
         write_entry(i, 1'b1, ids[i], $urandom_range(0, 7), $urandom_range(0, 7));
      end
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 15) == 0)
            write_entry($urandom_range(0, 63), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 1) ? ids[$urandom_range(0, 7)] : 24'($urandom)),
                        $urandom_range(0, 7), $urandom_range(0, 7));
         else
            send_pixel($urandom_range(0, 7) == 0 ? 24'($urandom) : ids[$urandom_range(0, 7)],
                       $urandom_range(0, 11) == 0);
      end
      send_pixel(ids[0], 1'b1);
   endtask

   // Long receiver hold-off while the sender keeps offering words.
   task automatic test_backpressure;
      hold_off = 1'b1;
      for (int i = 0; i < 40; i++) send_pixel(ids[i % 8], (i % 13) == 12);
      hold_off = 1'b0;
      send_pixel(ids[1], 1'b1);
      wait_idle();
   endtask

   task automatic test_settings_sweep;
      write_register(CSR_FRAME_WIDTH, 13'd1);
      write_register(CSR_CLASS_MASK, 13'h0FF);
      test_random_frames(40);
      write_register(CSR_FRAME_WIDTH, 13'd4096);
      write_register(CSR_CLASS_MASK, 13'h05A);
      test_random_frames(40);
      write_register(CSR_FRAME_WIDTH, 13'd7);
      write_register(CSR_CLASS_MASK, 13'h0FF);
      test_random_frames(80);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_settings_sweep();
      test_backpressure();
      noisy = 1'b0;
      write_register(CSR_FRAME_WIDTH, 13'd3);
      test_random_frames(80);
      wait_idle();
      if (mismatches == 0) $display("label_bounding_box_accumulator regression: pass");
      else $display("label_bounding_box_accumulator regression: fail");
      $finish;
   end

   // Receiver stall: random bursts, or a long counted hold-off.
   initial begin
      int burst;
      int held;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            held = 0;
            rsp_stall <= 1'b1;
            while (held < 300) begin
               @(negedge clock);
               held++;
            end
            rsp_stall <= 1'b0;
            wait (!hold_off);
         end else if (noisy && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted box with the oldest expectation.
   always @(posedge clock) begin
      box_type seen;
      box_type want;
      seen = '{rsp_box_valid, rsp_box_class, rsp_box_slot, rsp_min_row, rsp_max_row,
               rsp_min_col, rsp_max_col, rsp_last};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_boxes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected box %h", seen);
         end else begin
            want = expected_boxes.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("box mismatch: expected %h, got %h", want, seen);
            end
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("label_bounding_box_accumulator regression: fail");
         $finish;
      end
   end
endmodule
`default_nettype wire
